### rtl/hsvf_pkg.sv
// shared widths, constants and register codes of the hsv colour fader
package hsvf_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int TIME_W     = 32;
    localparam int HUE_W      = 17;
    localparam int PCT_W      = 15;
    localparam int BYTE_W     = 8;
    localparam int GAIN_W     = 9;
    localparam int INTERVAL_W = 16;
    localparam int DBAND_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // gain is applied in 1/256 steps regardless of the fixed point format
    localparam int GAIN_SHIFT = 8;
    localparam int GAIN_MAX   = 1 << GAIN_SHIFT;

    localparam int HUE_DEG    = 360;
    localparam int PCT_SPAN   = 100;
    localparam int HUE_FULL   = HUE_DEG << FRAC_BITS;
    localparam int HUE_HALF   = (HUE_DEG / 2) << FRAC_BITS;
    localparam int BYTE_MAX   = 255;

    // exact reciprocals for floor(q / 360) and floor(q / 100), q below 2**Q_W
    localparam int    Q_W          = 17;
    localparam int    HUE_RECIP_SH = 26;
    localparam int    PCT_RECIP_SH = 24;
    localparam int    RECIP_W      = 18;
    localparam longint HUE_RECIP   = ((64'd1 << HUE_RECIP_SH) + HUE_DEG - 1) / HUE_DEG;
    localparam longint PCT_RECIP   = ((64'd1 << PCT_RECIP_SH) + PCT_SPAN - 1) / PCT_SPAN;

    localparam int STEP_GAIN_RST      = 26;
    localparam int FRAME_INTERVAL_RST = 20;
    localparam int DEAD_BAND_RST      = 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_GAIN      = 2'd0,
        CFG_FRAME_INTERVAL = 2'd1,
        CFG_DEAD_BAND      = 2'd2
    } cfg_reg_t;

endpackage

### rtl/hsvf_in_if.sv
// request channel carrying time stamp and colour targets
interface hsvf_in_if;
    logic                          valid;
    logic                          ready;
    logic [hsvf_pkg::TIME_W-1:0]   now_ms;
    logic [hsvf_pkg::HUE_W-1:0]    target_hue;
    logic [hsvf_pkg::PCT_W-1:0]    target_sat;
    logic [hsvf_pkg::PCT_W-1:0]    target_val;
    logic                          target_power;

    modport source (
        output valid, now_ms, target_hue, target_sat, target_val, target_power,
        input  ready
    );
    modport sink (
        input  valid, now_ms, target_hue, target_sat, target_val, target_power,
        output ready
    );
endinterface

### rtl/hsvf_out_if.sv
// result channel carrying byte scaled colour
interface hsvf_out_if;
    logic                          valid;
    logic                          ready;
    logic                          lit;
    logic [hsvf_pkg::BYTE_W-1:0]   hue_byte;
    logic [hsvf_pkg::BYTE_W-1:0]   sat_byte;
    logic [hsvf_pkg::BYTE_W-1:0]   val_byte;

    modport source (
        output valid, lit, hue_byte, sat_byte, val_byte,
        input  ready
    );
    modport sink (
        input  valid, lit, hue_byte, sat_byte, val_byte,
        output ready
    );
endinterface

### rtl/hsv_color_fader.sv
// hsv colour fader top level: frame gate, per channel fade and byte scaling
//
// The fader takes one request per clock cycle. A request passes through an
// input register, then the update cycle in which the frame timer gate,
// the three channel fades (one multiply by the gain per channel) and the hue
// wrap are all evaluated against the current state and written back together
// with a snapshot of the new colour, then the byte scaling into an output
// register. A request that opens a frame and changes something shows its
// result via the snapshot and output registers on the result channel; early
// requests and frames without change give none. Back-pressure on the result
// channel stalls the stages behind it, but every stage keeps taking requests
// while the stage ahead of it has room, so a waiting result stops the input
// only once the snapshot and input registers behind it are both full.
// Configuration writes are meant to be made while the fader is idle.
module hsv_color_fader (
    input  logic                                clk,
    input  logic                                rst_n,
    hsvf_in_if.sink                             target,
    hsvf_out_if.source                          result,
    input  logic                                cfg_wr_en,
    input  logic [hsvf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hsvf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int HD_W   = hsvf_pkg::HUE_W + 2;          // signed hue arithmetic
    localparam int PD_W   = hsvf_pkg::PCT_W + 1;          // signed sat/val difference
    localparam int G_W    = hsvf_pkg::GAIN_W + 1;         // signed gain
    localparam int HP_W   = HD_W + G_W;
    localparam int PP_W   = PD_W + G_W;
    localparam int HS_W   = hsvf_pkg::HUE_W + hsvf_pkg::BYTE_W;
    localparam int PS_W   = hsvf_pkg::PCT_W + hsvf_pkg::BYTE_W;
    localparam int QP_W   = hsvf_pkg::Q_W + hsvf_pkg::RECIP_W;

    localparam logic signed [HD_W-1:0] HUE_FULL_S = HD_W'(hsvf_pkg::HUE_FULL);
    localparam logic signed [HD_W-1:0] HUE_HALF_S = HD_W'(hsvf_pkg::HUE_HALF);

    // configuration registers
    logic [hsvf_pkg::GAIN_W-1:0]      step_gain_reg;
    logic [hsvf_pkg::INTERVAL_W-1:0]  frame_interval_reg;
    logic [hsvf_pkg::DBAND_W-1:0]     dead_band_reg;

    // fader state
    logic [hsvf_pkg::TIME_W-1:0]      last_frame_time_reg, last_frame_time_next;
    logic [hsvf_pkg::HUE_W-1:0]       cur_hue_reg, cur_hue_next;
    logic [hsvf_pkg::PCT_W-1:0]       cur_sat_reg, cur_sat_next;
    logic [hsvf_pkg::PCT_W-1:0]       cur_val_reg, cur_val_next;
    logic                             cur_power_reg, cur_power_next;

    // input stage
    logic                             a_valid_reg, a_valid_next;
    logic [hsvf_pkg::TIME_W-1:0]      a_now_reg;
    logic [hsvf_pkg::HUE_W-1:0]       a_hue_reg;
    logic [hsvf_pkg::PCT_W-1:0]       a_sat_reg;
    logic [hsvf_pkg::PCT_W-1:0]       a_val_reg;
    logic                             a_power_reg;

    // snapshot stage, one per frame that changed something
    logic                             b_valid_reg, b_valid_next;
    logic                             b_lit_reg;
    logic [hsvf_pkg::HUE_W-1:0]       b_hue_reg;
    logic [hsvf_pkg::PCT_W-1:0]       b_sat_reg;
    logic [hsvf_pkg::PCT_W-1:0]       b_val_reg;

    // output register
    logic                             o_valid_reg, o_valid_next;
    logic                             o_lit_reg;
    logic [hsvf_pkg::BYTE_W-1:0]      o_hue_reg;
    logic [hsvf_pkg::BYTE_W-1:0]      o_sat_reg;
    logic [hsvf_pkg::BYTE_W-1:0]      o_val_reg;

    // handshake between stages
    logic                             o_free;
    logic                             b_free;
    logic                             a_free;
    logic                             a_fire;
    logic                             b_fire;
    logic                             in_fire;

    // update logic
    logic [hsvf_pkg::TIME_W-1:0]      elapsed;
    logic                             frame_open;
    logic [hsvf_pkg::GAIN_W-1:0]      gain_eff;
    logic signed [G_W-1:0]            gain_s;
    logic signed [HD_W-1:0]           dh, dh_abs, dh_w1, dh_w2;
    logic signed [HP_W-1:0]           hue_prod;
    logic signed [HD_W-1:0]           hue_step, h_sum, h_w1, h_w2, h_clamp;
    logic                             hue_move, sat_move, val_move;
    logic                             power_move;
    logic                             frame_changed;
    logic [hsvf_pkg::PCT_W-1:0]       sat_faded, val_faded;
    logic                             new_lit;

    // byte scaling
    logic [HS_W-1:0]                  hue_x255;
    logic [PS_W-1:0]                  sat_x255, val_x255;
    logic [hsvf_pkg::Q_W-1:0]         hue_q, sat_q, val_q;
    logic [QP_W-1:0]                  hue_qp, sat_qp, val_qp;
    logic [hsvf_pkg::BYTE_W-1:0]      hue_b, sat_b, val_b;

    // moves one percent channel toward its target, floored gain step
    function automatic logic [hsvf_pkg::PCT_W-1:0] pct_fade(
        input logic [hsvf_pkg::PCT_W-1:0] cur,
        input logic [hsvf_pkg::PCT_W-1:0] tgt,
        input logic signed [G_W-1:0]      gain
    );
        logic signed [PD_W-1:0] d;
        logic signed [PP_W-1:0] p;
        logic signed [PD_W-1:0] s;
        logic signed [PD_W-1:0] sum;
        d   = $signed({1'b0, tgt}) - $signed({1'b0, cur});
        p   = PP_W'(d) * PP_W'(gain);
        s   = p[hsvf_pkg::GAIN_SHIFT +: PD_W];
        sum = $signed({1'b0, cur}) + s;
        return sum[hsvf_pkg::PCT_W-1:0];
    endfunction

    // gap above dead band on a percent channel
    function automatic logic pct_gap_big(
        input logic [hsvf_pkg::PCT_W-1:0]   cur,
        input logic [hsvf_pkg::PCT_W-1:0]   tgt,
        input logic [hsvf_pkg::DBAND_W-1:0] db
    );
        logic [hsvf_pkg::PCT_W-1:0] gap;
        gap = (cur > tgt) ? (cur - tgt) : (tgt - cur);
        return gap > hsvf_pkg::PCT_W'(db);
    endfunction

    // percent to byte, saturated for targets above full scale
    function automatic logic [hsvf_pkg::BYTE_W-1:0] pct_byte(
        input logic [QP_W-1:0] qp
    );
        logic [QP_W-1:0] b;
        b = qp >> hsvf_pkg::PCT_RECIP_SH;
        return (b > QP_W'(hsvf_pkg::BYTE_MAX)) ? hsvf_pkg::BYTE_W'(hsvf_pkg::BYTE_MAX)
                                               : b[hsvf_pkg::BYTE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stage handshakes: each stage takes a new entry when the one ahead
    // has room or is draining this cycle
    // ------------------------------------------------------------------
    assign o_free  = !o_valid_reg || result.ready;
    assign b_free  = !b_valid_reg || o_free;
    assign a_free  = !a_valid_reg || b_free;
    assign a_fire  = a_valid_reg && b_free;
    assign b_fire  = b_valid_reg && o_free;
    assign in_fire = target.valid && target.ready;

    assign target.ready = a_free;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gain_reg      <= hsvf_pkg::GAIN_W'(hsvf_pkg::STEP_GAIN_RST);
            frame_interval_reg <= hsvf_pkg::INTERVAL_W'(hsvf_pkg::FRAME_INTERVAL_RST);
            dead_band_reg      <= hsvf_pkg::DBAND_W'(hsvf_pkg::DEAD_BAND_RST);
        end
        else if (cfg_wr_en)
        begin
            case (hsvf_pkg::cfg_reg_t'(cfg_index))
                hsvf_pkg::CFG_STEP_GAIN:
                    step_gain_reg <= cfg_data[hsvf_pkg::GAIN_W-1:0];
                hsvf_pkg::CFG_FRAME_INTERVAL:
                    frame_interval_reg <= cfg_data[hsvf_pkg::INTERVAL_W-1:0];
                hsvf_pkg::CFG_DEAD_BAND:
                    dead_band_reg <= cfg_data[hsvf_pkg::DBAND_W-1:0];
                default:
                    ; // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_free)
            a_valid_next = target.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_now_reg   <= target.now_ms;
            a_hue_reg   <= target.target_hue;
            a_sat_reg   <= target.target_sat;
            a_val_reg   <= target.target_val;
            a_power_reg <= target.target_power;
        end
    end

    // ------------------------------------------------------------------
    // update cycle
    // ------------------------------------------------------------------

    // frame gate, modulo 2^32 elapsed time
    assign elapsed    = a_now_reg - last_frame_time_reg;
    assign frame_open = elapsed >= hsvf_pkg::TIME_W'(frame_interval_reg);

    // gain above unity is held at unity
    assign gain_eff = (step_gain_reg > hsvf_pkg::GAIN_W'(hsvf_pkg::GAIN_MAX))
                    ? hsvf_pkg::GAIN_W'(hsvf_pkg::GAIN_MAX) : step_gain_reg;
    assign gain_s   = $signed({1'b0, gain_eff});

    // hue: plain gap for the dead band test, shortest way round for the step
    always_comb
    begin
        dh     = $signed(HD_W'(a_hue_reg)) - $signed(HD_W'(cur_hue_reg));
        dh_abs = (dh < 0) ? -dh : dh;
        hue_move = dh_abs > $signed(HD_W'(dead_band_reg));

        // the corrections are tested in turn, as in the plain sequence; at most one applies
        dh_w1 = (dh > HUE_HALF_S) ? (dh - HUE_FULL_S) : dh;
        dh_w2 = (dh_w1 < -HUE_HALF_S) ? (dh_w1 + HUE_FULL_S) : dh_w1;

        hue_prod = HP_W'(dh_w2) * HP_W'(gain_s);
        hue_step = hue_prod[hsvf_pkg::GAIN_SHIFT +: HD_W];   // floor by arithmetic shift

        h_sum = $signed(HD_W'(cur_hue_reg)) + hue_step;
        h_w1  = (h_sum < 0) ? (h_sum + HUE_FULL_S) : h_sum;
        h_w2  = (h_w1 > HUE_FULL_S) ? (h_w1 - HUE_FULL_S) : h_w1;

        // clamp is only a guard: the wraps above already keep the hue within a full turn
        if (h_w2 < 0)
            h_clamp = '0;
        else if (h_w2 > HUE_FULL_S)
            h_clamp = HUE_FULL_S;
        else
            h_clamp = h_w2;
    end

    assign sat_move   = pct_gap_big(cur_sat_reg, a_sat_reg, dead_band_reg);
    assign val_move   = pct_gap_big(cur_val_reg, a_val_reg, dead_band_reg);
    assign sat_faded  = pct_fade(cur_sat_reg, a_sat_reg, gain_s);
    assign val_faded  = pct_fade(cur_val_reg, a_val_reg, gain_s);
    assign power_move = cur_power_reg != a_power_reg;

    // a channel over the dead band counts as change even with a zero step
    assign frame_changed = power_move || hue_move || sat_move || val_move;

    always_comb
    begin
        last_frame_time_next = last_frame_time_reg;
        cur_power_next       = cur_power_reg;
        cur_hue_next         = cur_hue_reg;
        cur_sat_next         = cur_sat_reg;
        cur_val_next         = cur_val_reg;
        if (a_fire && frame_open)
        begin
            last_frame_time_next = a_now_reg;
            cur_power_next       = a_power_reg;
            if (hue_move)
                cur_hue_next = h_clamp[hsvf_pkg::HUE_W-1:0];
            if (sat_move)
                cur_sat_next = sat_faded;
            if (val_move)
                cur_val_next = val_faded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frame_time_reg <= '0;
            cur_hue_reg         <= '0;
            cur_sat_reg         <= '0;
            cur_val_reg         <= '0;
            cur_power_reg       <= 1'b0;
        end
        else
        begin
            last_frame_time_reg <= last_frame_time_next;
            cur_hue_reg         <= cur_hue_next;
            cur_sat_reg         <= cur_sat_next;
            cur_val_reg         <= cur_val_next;
            cur_power_reg       <= cur_power_next;
        end
    end

    // ------------------------------------------------------------------
    // snapshot of the new colour for frames that changed something
    // ------------------------------------------------------------------
    assign new_lit = cur_power_next && (cur_val_next != '0);

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_free)
            b_valid_next = a_fire && frame_open && frame_changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_free)
        begin
            b_lit_reg <= new_lit;
            b_hue_reg <= cur_hue_next;
            b_sat_reg <= cur_sat_next;
            b_val_reg <= cur_val_next;
        end
    end

    // ------------------------------------------------------------------
    // byte scaling: times 255 by shift and subtract, drop the fraction,
    // then divide by 360 or 100 through an exact reciprocal
    // ------------------------------------------------------------------
    assign hue_x255 = (HS_W'(b_hue_reg) << hsvf_pkg::BYTE_W) - HS_W'(b_hue_reg);
    assign sat_x255 = (PS_W'(b_sat_reg) << hsvf_pkg::BYTE_W) - PS_W'(b_sat_reg);
    assign val_x255 = (PS_W'(b_val_reg) << hsvf_pkg::BYTE_W) - PS_W'(b_val_reg);

    assign hue_q = hsvf_pkg::Q_W'(hue_x255 >> hsvf_pkg::FRAC_BITS);
    assign sat_q = hsvf_pkg::Q_W'(sat_x255 >> hsvf_pkg::FRAC_BITS);
    assign val_q = hsvf_pkg::Q_W'(val_x255 >> hsvf_pkg::FRAC_BITS);

    assign hue_qp = QP_W'(hue_q) * QP_W'(hsvf_pkg::HUE_RECIP);
    assign sat_qp = QP_W'(sat_q) * QP_W'(hsvf_pkg::PCT_RECIP);
    assign val_qp = QP_W'(val_q) * QP_W'(hsvf_pkg::PCT_RECIP);

    // hue never exceeds a full turn, so its byte cannot overflow
    assign hue_b = hsvf_pkg::BYTE_W'(hue_qp >> hsvf_pkg::HUE_RECIP_SH);
    assign sat_b = pct_byte(sat_qp);
    assign val_b = pct_byte(val_qp);

    // ------------------------------------------------------------------
    // output register, black when dark
    // ------------------------------------------------------------------
    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (o_free)
            o_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else
            o_valid_reg <= o_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            o_lit_reg <= b_lit_reg;
            o_hue_reg <= b_lit_reg ? hue_b : '0;
            o_sat_reg <= b_lit_reg ? sat_b : '0;
            o_val_reg <= b_lit_reg ? val_b : '0;
        end
    end

    assign result.valid    = o_valid_reg;
    assign result.lit      = o_lit_reg;
    assign result.hue_byte = o_hue_reg;
    assign result.sat_byte = o_sat_reg;
    assign result.val_byte = o_val_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // hue state stays on the circle
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_hue_reg <= hsvf_pkg::HUE_W'(hsvf_pkg::HUE_FULL))
        else $error("hue state beyond a full turn");

    // an early request leaves the whole state alone
    a_early_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        a_fire && !frame_open |=> $stable(last_frame_time_reg) && $stable(cur_hue_reg)
            && $stable(cur_sat_reg) && $stable(cur_val_reg) && $stable(cur_power_reg))
        else $error("early request altered fader state");

    // a new snapshot only comes from a frame that changed something
    a_snapshot_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(b_valid_reg) |-> $past(a_fire && frame_open && frame_changed))
        else $error("snapshot without a changing frame");

    // dark results carry black
    a_dark_black: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_lit_reg |-> (o_hue_reg == '0) && (o_sat_reg == '0)
            && (o_val_reg == '0))
        else $error("dark result with colour");

endmodule

### dv/hsv_color_fader_tb.sv
// self-checking testbench for the hsv colour fader: fade predictor, scoreboard and stimulus
module hsv_color_fader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // saturation and brightness full scale, 100 percent in fixed point
    localparam int PCT_FULL      = hsvf_pkg::PCT_SPAN << hsvf_pkg::FRAC_BITS;
    // pipeline is three deep, leave a few more cycles before touching registers
    localparam int SETTLE_CYCLES = 10;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [hsvf_pkg::TIME_W-1:0] now_ms;
        logic [hsvf_pkg::HUE_W-1:0]  hue;
        logic [hsvf_pkg::PCT_W-1:0]  sat;
        logic [hsvf_pkg::PCT_W-1:0]  val;
        logic                        power;
    } target_req_t;

    typedef struct packed {
        logic                        lit;
        logic [hsvf_pkg::BYTE_W-1:0] hue_b;
        logic [hsvf_pkg::BYTE_W-1:0] sat_b;
        logic [hsvf_pkg::BYTE_W-1:0] val_b;
    } colour_out_t;

    // tracks the fader state, predicts each frame and checks results in order
    class fade_scoreboard;
        bit [hsvf_pkg::GAIN_W-1:0]     gain;
        bit [hsvf_pkg::INTERVAL_W-1:0] interval;
        bit [hsvf_pkg::DBAND_W-1:0]    band;
        bit [hsvf_pkg::TIME_W-1:0]     last_frame;
        bit [hsvf_pkg::HUE_W-1:0]      hue;
        bit [hsvf_pkg::PCT_W-1:0]      sat;
        bit [hsvf_pkg::PCT_W-1:0]      val;
        bit                            power;
        colour_out_t                   pending_colours[$];
        int unsigned                   requests;
        int unsigned                   frames;
        int unsigned                   checked;
        int unsigned                   mismatches;

        function new();
            gain       = hsvf_pkg::GAIN_W'(hsvf_pkg::STEP_GAIN_RST);
            interval   = hsvf_pkg::INTERVAL_W'(hsvf_pkg::FRAME_INTERVAL_RST);
            band       = hsvf_pkg::DBAND_W'(hsvf_pkg::DEAD_BAND_RST);
            last_frame = '0;
            hue        = '0;
            sat        = '0;
            val        = '0;
            power      = 1'b0;
        endfunction

        function void write_reg(hsvf_pkg::cfg_reg_t idx, bit [hsvf_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                hsvf_pkg::CFG_STEP_GAIN:      gain     = data[hsvf_pkg::GAIN_W-1:0];
                hsvf_pkg::CFG_FRAME_INTERVAL: interval = data[hsvf_pkg::INTERVAL_W-1:0];
                hsvf_pkg::CFG_DEAD_BAND:      band     = data[hsvf_pkg::DBAND_W-1:0];
                default: ;
            endcase
        endfunction

        // floored gain fraction of a signed gap
        function longint gain_move(longint gap);
            longint g;
            g = (gain > hsvf_pkg::GAIN_MAX) ? hsvf_pkg::GAIN_MAX : gain;
            return (gap * g) >>> hsvf_pkg::GAIN_SHIFT;
        endfunction

        function longint magnitude(longint x);
            return (x < 0) ? -x : x;
        endfunction

        function bit [hsvf_pkg::BYTE_W-1:0] byte_scale(longint v, longint full);
            longint b;
            b = (v * hsvf_pkg::BYTE_MAX) / full;
            return hsvf_pkg::BYTE_W'((b > hsvf_pkg::BYTE_MAX) ? hsvf_pkg::BYTE_MAX : b);
        endfunction

        function void note_request(target_req_t r);
            bit [hsvf_pkg::TIME_W-1:0] elapsed;
            longint                    db;
            longint                    d;
            longint                    h;
            bit                        changed;
            bit                        lit;
            colour_out_t               c;
            requests++;
            elapsed = r.now_ms - last_frame;
            if (elapsed < interval)
                return;
            frames++;
            last_frame = r.now_ms;
            db = band;
            changed = 1'b0;
            if (power != r.power)
            begin
                power = r.power;
                changed = 1'b1;
            end
            // gate on the plain gap, then move the short way round the circle
            if (magnitude(longint'(hue) - longint'(r.hue)) > db)
            begin
                d = longint'(r.hue) - longint'(hue);
                if (d > hsvf_pkg::HUE_HALF)
                    d -= hsvf_pkg::HUE_FULL;
                if (d < -hsvf_pkg::HUE_HALF)
                    d += hsvf_pkg::HUE_FULL;
                h = longint'(hue) + gain_move(d);
                if (h < 0)
                    h += hsvf_pkg::HUE_FULL;
                if (h > hsvf_pkg::HUE_FULL)
                    h -= hsvf_pkg::HUE_FULL;
                if (h < 0)
                    h = 0;
                if (h > hsvf_pkg::HUE_FULL)
                    h = hsvf_pkg::HUE_FULL;
                hue = h[hsvf_pkg::HUE_W-1:0];
                changed = 1'b1;
            end
            if (magnitude(longint'(sat) - longint'(r.sat)) > db)
            begin
                h = longint'(sat) + gain_move(longint'(r.sat) - longint'(sat));
                sat = h[hsvf_pkg::PCT_W-1:0];
                changed = 1'b1;
            end
            if (magnitude(longint'(val) - longint'(r.val)) > db)
            begin
                h = longint'(val) + gain_move(longint'(r.val) - longint'(val));
                val = h[hsvf_pkg::PCT_W-1:0];
                changed = 1'b1;
            end
            if (!changed)
                return;
            lit     = power && (val != 0);
            c.lit   = lit;
            c.hue_b = lit ? byte_scale(hue, hsvf_pkg::HUE_FULL) : '0;
            c.sat_b = lit ? byte_scale(sat, PCT_FULL) : '0;
            c.val_b = lit ? byte_scale(val, PCT_FULL) : '0;
            pending_colours.push_back(c);
        endfunction

        function void check_result(colour_out_t got);
            colour_out_t want;
            if (pending_colours.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%t unexpected result lit %0b hue %0d sat %0d val %0d",
                             $realtime, got.lit, got.hue_b, got.sat_b, got.val_b);
                return;
            end
            want = pending_colours.pop_front();
            checked++;
            if (got.lit !== want.lit || got.hue_b !== want.hue_b ||
                got.sat_b !== want.sat_b || got.val_b !== want.val_b)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%t result %0d: expected lit %0b hue %0d sat %0d val %0d, %s %0b %0d %0d %0d",
                             $realtime, checked, want.lit, want.hue_b, want.sat_b,
                             want.val_b, "got", got.lit, got.hue_b, got.sat_b, got.val_b);
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [hsvf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hsvf_pkg::CFG_DATA_W-1:0] cfg_data;

    hsvf_in_if  target_ch ();
    hsvf_out_if result_ch ();

    hsv_color_fader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .target    (target_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fade_scoreboard board;

    // chance of an idle burst is one in n per request or cycle, zero means none
    int unsigned src_odds;
    int unsigned snk_odds;
    int unsigned settings_used;

    // register settings per phase: gain, interval, dead band
    // gain above 256 saturates; the fourth entry carries junk above the register widths
    int unsigned phase_gain[7]     = '{256, 0, 16'h01FF, 16'hAB2C, 1, 128, 64};
    int unsigned phase_interval[7] = '{0, 65535, 1, 7, 20, 3, 250};
    int unsigned phase_band[7]     = '{0, 255, 0, 16'h3380, 1, 5, 40};
    int unsigned phase_frames[7]   = '{170, 170, 170, 170, 170, 170, 190};

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // result side: random stall bursts on ready
    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (snk_odds != 0 && $urandom_range(1, snk_odds) == 1)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // result monitor, values sampled as they stood before the edge
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_result({result_ch.lit, result_ch.hue_byte,
                                result_ch.sat_byte, result_ch.val_byte});
    end

    function automatic target_req_t make_req(logic [hsvf_pkg::TIME_W-1:0] t, int unsigned h,
                                             int unsigned s, int unsigned v, bit p);
        target_req_t r;
        r.now_ms = t;
        r.hue    = hsvf_pkg::HUE_W'(h);
        r.sat    = hsvf_pkg::PCT_W'(s);
        r.val    = hsvf_pkg::PCT_W'(v);
        r.power  = p;
        return r;
    endfunction

    // offer one request, with an optional idle burst ahead of it, and wait for the handshake
    task automatic send_target(target_req_t r);
        if (src_odds != 0 && $urandom_range(1, src_odds) == 1)
        begin
            target_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        target_ch.valid        <= 1'b1;
        target_ch.now_ms       <= r.now_ms;
        target_ch.target_hue   <= r.hue;
        target_ch.target_sat   <= r.sat;
        target_ch.target_val   <= r.val;
        target_ch.target_power <= r.power;
        @(posedge clk);
        while (!target_ch.ready)
            @(posedge clk);
        board.note_request(r);
    endtask

    // drop valid, let every expected colour come out, then give the pipeline time to empty
    task automatic settle();
        target_ch.valid <= 1'b0;
        while (board.pending_colours.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all three registers on consecutive cycles, write enable dropped once at the end
    task automatic program_fader(bit [hsvf_pkg::CFG_DATA_W-1:0] gain,
                                 bit [hsvf_pkg::CFG_DATA_W-1:0] interval,
                                 bit [hsvf_pkg::CFG_DATA_W-1:0] band);
        cfg_wr_en <= 1'b1;
        cfg_index <= hsvf_pkg::CFG_STEP_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        board.write_reg(hsvf_pkg::CFG_STEP_GAIN, gain);
        cfg_index <= hsvf_pkg::CFG_FRAME_INTERVAL;
        cfg_data  <= interval;
        @(posedge clk);
        board.write_reg(hsvf_pkg::CFG_FRAME_INTERVAL, interval);
        cfg_index <= hsvf_pkg::CFG_DEAD_BAND;
        cfg_data  <= band;
        @(posedge clk);
        board.write_reg(hsvf_pkg::CFG_DEAD_BAND, band);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // mostly one frame interval on from the last frame, sometimes early, sometimes anywhere
    function automatic logic [hsvf_pkg::TIME_W-1:0] next_stamp();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10 && board.interval != 0)
            return board.last_frame + $urandom_range(0, board.interval - 1);
        if (roll < 14)
            return $urandom();
        return board.last_frame + board.interval + $urandom_range(0, 3);
    endfunction

    // a fade target held for a run of frames
    function automatic target_req_t pick_target();
        target_req_t r;
        r = '0;
        r.power = ($urandom_range(0, 5) != 0);
        case ($urandom_range(0, 5))
            0:
            begin
                r.hue = hsvf_pkg::HUE_W'($urandom_range(0, hsvf_pkg::HUE_FULL));
                r.sat = hsvf_pkg::PCT_W'($urandom_range(0, PCT_FULL));
                r.val = hsvf_pkg::PCT_W'($urandom_range(0, PCT_FULL));
            end
            1:
            begin
                // corners of the legal range
                r.hue = hsvf_pkg::HUE_W'($urandom_range(0, 1) ? hsvf_pkg::HUE_FULL : 0);
                r.sat = hsvf_pkg::PCT_W'($urandom_range(0, 1) ? PCT_FULL : 0);
                r.val = hsvf_pkg::PCT_W'($urandom_range(0, 1) ? PCT_FULL : 0);
            end
            2:
            begin
                // either side of the 0/360 seam
                r.hue = hsvf_pkg::HUE_W'($urandom_range(0, 1)
                                         ? $urandom_range(0, 3000)
                                         : hsvf_pkg::HUE_FULL - $urandom_range(0, 3000));
                r.sat = hsvf_pkg::PCT_W'($urandom_range(0, PCT_FULL));
                r.val = hsvf_pkg::PCT_W'($urandom_range(0, PCT_FULL));
            end
            3:
            begin
                // beyond 360 degrees and 100 percent, up to the field widths
                r.hue = hsvf_pkg::HUE_W'($urandom_range(hsvf_pkg::HUE_FULL,
                                                        (1 << hsvf_pkg::HUE_W) - 1));
                r.sat = hsvf_pkg::PCT_W'($urandom_range(PCT_FULL, (1 << hsvf_pkg::PCT_W) - 1));
                r.val = hsvf_pkg::PCT_W'($urandom_range(PCT_FULL, (1 << hsvf_pkg::PCT_W) - 1));
            end
            4:
            begin
                // close to where the fade already is, often inside the dead band
                r.hue = hsvf_pkg::HUE_W'(board.hue + $urandom_range(0, board.band + 2));
                r.sat = hsvf_pkg::PCT_W'(board.sat - $urandom_range(0, board.band + 2));
                r.val = hsvf_pkg::PCT_W'(board.val + $urandom_range(0, board.band + 2));
                r.power = board.power;
            end
            default:
            begin
                // dark: brightness at or near zero
                r.hue = hsvf_pkg::HUE_W'($urandom_range(0, hsvf_pkg::HUE_FULL));
                r.sat = hsvf_pkg::PCT_W'($urandom_range(0, PCT_FULL));
                r.val = hsvf_pkg::PCT_W'($urandom_range(0, 1) ? 0 : $urandom_range(0, 300));
            end
        endcase
        return r;
    endfunction

    // random fades until n more frames have been opened
    task automatic run_fades(int unsigned n_frames);
        target_req_t seq;
        target_req_t req;
        int unsigned goal;
        int unsigned hold;
        goal = board.frames + n_frames;
        while (board.frames < goal)
        begin
            seq  = pick_target();
            hold = $urandom_range(1, 40);
            while (hold != 0 && board.frames < goal)
            begin
                hold--;
                if ($urandom_range(0, 11) == 0)
                    seq.power = ~seq.power;
                req = seq;
                if ($urandom_range(0, 15) == 0)
                begin
                    // noise request, every field random
                    req.hue   = hsvf_pkg::HUE_W'($urandom());
                    req.sat   = hsvf_pkg::PCT_W'($urandom());
                    req.val   = hsvf_pkg::PCT_W'($urandom());
                    req.power = 1'($urandom());
                end
                req.now_ms = next_stamp();
                send_target(req);
            end
        end
    endtask

    // hand-picked requests under the reset register values (gain 26, interval 20, band 26)
    task automatic directed_checks();
        int unsigned all_hue;
        int unsigned all_pct;
        all_hue = (1 << hsvf_pkg::HUE_W) - 1;
        all_pct = (1 << hsvf_pkg::PCT_W) - 1;
        send_target(make_req(32'd5, hsvf_pkg::HUE_FULL, PCT_FULL, PCT_FULL, 1'b1));  // early
        send_target(make_req(32'd19, hsvf_pkg::HUE_FULL, PCT_FULL, PCT_FULL, 1'b1)); // one short
        send_target(make_req(32'd20, hsvf_pkg::HUE_FULL, PCT_FULL, PCT_FULL, 1'b1)); // due
        send_target(make_req(32'd25, hsvf_pkg::HUE_FULL, PCT_FULL, PCT_FULL, 1'b1)); // early
        send_target(make_req(32'd40, hsvf_pkg::HUE_FULL, PCT_FULL, PCT_FULL, 1'b1));
        send_target(make_req(32'hFFFF_FFF0, 0, 0, 0, 1'b1));
        // across the time stamp wrap: 19 ms is early, 20 ms is due
        send_target(make_req(32'h0000_0003, 0, 0, 0, 1'b1));
        send_target(make_req(32'h0000_0004, 0, 0, 0, 1'b1));
        // all-ones targets, out of range on every channel
        send_target(make_req(32'd24, all_hue, all_pct, all_pct, 1'b1));
        send_target(make_req(32'd44, all_hue, all_pct, all_pct, 1'b0));
        send_target(make_req(32'd64, all_hue, all_pct, all_pct, 1'b1));
        // target equal to the present state: a frame with no change
        send_target(make_req(32'd84, board.hue, board.sat, board.val, board.power));
        // gap exactly at the dead band, then one past it
        send_target(make_req(32'd104, board.hue + board.band, board.sat, board.val, 1'b1));
        send_target(make_req(32'd124, board.hue + board.band + 1, board.sat, board.val, 1'b1));
        // hue either side of the seam
        send_target(make_req(32'd144, 300, PCT_FULL, PCT_FULL, 1'b1));
        send_target(make_req(32'd164, hsvf_pkg::HUE_FULL - 300, PCT_FULL, PCT_FULL, 1'b1));
        send_target(make_req(32'd184, 300, PCT_FULL, 0, 1'b1));
        // power off while bright, then brightness target zero
        send_target(make_req(32'd204, 300, PCT_FULL, PCT_FULL, 1'b0));
        send_target(make_req(32'd224, 300, PCT_FULL, 0, 1'b1));
        send_target(make_req(32'd244, hsvf_pkg::HUE_HALF, 0, 0, 1'b1));
    endtask

    initial
    begin
        board = new();
        settings_used = 1;
        src_odds  = 0;
        snk_odds  = 0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        target_ch.valid        = 1'b0;
        target_ch.now_ms       = '0;
        target_ch.target_hue   = '0;
        target_ch.target_sat   = '0;
        target_ch.target_val   = '0;
        target_ch.target_power = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part straight out of reset, then random fades on reset settings
        directed_checks();
        src_odds = 4;
        snk_odds = 6;
        run_fades(170);
        settle();

        // register phases, each with its own idling mix; the last one runs flat out
        for (int p = 0; p < 7; p++)
        begin
            program_fader(hsvf_pkg::CFG_DATA_W'(phase_gain[p]),
                          hsvf_pkg::CFG_DATA_W'(phase_interval[p]),
                          hsvf_pkg::CFG_DATA_W'(phase_band[p]));
            case ($urandom_range(0, 2))
                0:
                begin
                    src_odds = 0;
                    snk_odds = 0;
                end
                1:
                begin
                    src_odds = 3;
                    snk_odds = 4;
                end
                default:
                begin
                    src_odds = 12;
                    snk_odds = 10;
                end
            endcase
            if (p == 6)
            begin
                src_odds = 0;
                snk_odds = 0;
            end
            run_fades(phase_frames[p]);
            settle();
        end

        $display("fader run: %0d requests, %0d frames, %0d colours checked, %0d mismatches",
                 board.requests, board.frames, board.checked, board.mismatches);
        $display("covered %0d register settings incl. gain 0 and saturated, interval 0 and 65535",
                 settings_used);
        if (board.mismatches == 0 && board.pending_colours.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
